[sv/plc_pkg.sv]
// Shared types, codes and fixed-point helpers for the pad LED color controller.
`default_nettype none

package plc_pkg;

    // request codes
    localparam logic [2:0] REQ_PRESS    = 3'd0;
    localparam logic [2:0] REQ_PAD_RGB  = 3'd1;
    localparam logic [2:0] REQ_GLOW_RGB = 3'd2;
    localparam logic [2:0] REQ_STANDBY  = 3'd3;
    localparam logic [2:0] REQ_TICK     = 3'd4;
    localparam logic [2:0] REQ_REFRESH  = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_CEIL_PCT  = 3'd0;
    localparam logic [2:0] CFG_IDLE_PCT  = 3'd1;
    localparam logic [2:0] CFG_ROOT_PCT  = 3'd2;
    localparam logic [2:0] CFG_GLOW_LVL  = 3'd3;
    localparam logic [2:0] CFG_ROOT_MASK = 3'd4;
    localparam logic [2:0] CFG_NAT_MASK  = 3'd5;

    localparam logic [6:0]  CEIL_PCT_RST  = 7'd100;
    localparam logic [6:0]  IDLE_PCT_RST  = 7'd25;
    localparam logic [6:0]  ROOT_PCT_RST  = 7'd15;
    localparam logic [7:0]  GLOW_LVL_RST  = 8'd230;
    localparam logic [23:0] GLOW_RGB_RST  = 24'hFF_FFFF;
    localparam logic [6:0]  PCT_MAX       = 7'd100;
    // cycles for the level pipeline to follow a register write
    localparam logic [2:0]  LEVEL_SETTLE  = 3'd4;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] logical_pad;
        logic [7:0] underglow_index;
        logic [7:0] press_level;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       standby_on;
    } plc_cmd_t;

    typedef struct packed {
        logic       chain_sel;
        logic [4:0] pixel_slot;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_write;
    } plc_px_t;

    // one pixel to be colored
    typedef struct packed {
        logic        chain;
        logic [4:0]  slot;
        logic [7:0]  press;
        logic [23:0] rgb;
        logic        last;
    } plc_pix_t;

    typedef struct packed {
        logic [7:0] ceil;
        logic [7:0] base;
        logic [7:0] root;
    } plc_levels_t;

    function automatic logic [6:0] sat_pct(input logic [6:0] p);
        return (p > PCT_MAX) ? PCT_MAX : p;
    endfunction

    // floor(x / 100) for x below 25600
    function automatic logic [7:0] div100(input logic [14:0] x);
        logic [27:0] p;
        p = {13'd0, x} * 28'd5243;
        return p[26:19];
    endfunction

    // floor(x / 255) for any 16-bit x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return s[15:8];
    endfunction

endpackage

`default_nettype wire

[sv/plc_levels.sv]
// Brightness level pipeline: ceiling, idle baseline and root level from the percent registers.
`default_nettype none

module plc_levels
    import plc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [6:0]  ceil_pct,
    input  wire logic [6:0]  idle_pct,
    input  wire logic [6:0]  root_pct,
    output plc_levels_t      lv
);

    logic [14:0] cp_reg;
    logic [7:0]  ceil_reg;
    logic [14:0] bp_reg;
    logic [14:0] rp_reg;
    logic [7:0]  base_reg;
    logic [7:0]  root_reg;

    always_ff @(posedge clk)
    begin
        cp_reg   <= {8'd0, sat_pct(ceil_pct)} * 15'd255;
        ceil_reg <= div100(cp_reg);
        bp_reg   <= {7'd0, ceil_reg} * {8'd0, sat_pct(idle_pct)};
        rp_reg   <= {7'd0, ceil_reg} * {8'd0, sat_pct(root_pct)};
        base_reg <= div100(bp_reg);
        root_reg <= div100(rp_reg);
    end

    assign lv = '{ceil: ceil_reg, base: base_reg, root: root_reg};

endmodule

`default_nettype wire

[sv/plc_color.sv]
// Pixel color unit: registered channel products, then divide by 255 and offset, or a constant color.
`default_nettype none

module plc_color
    import plc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        load,
    input  plc_pix_t         pix,
    input  wire logic        standby,
    input  plc_levels_t      lv,
    input  wire logic [7:0]  glow_lvl,
    input  wire logic [23:0] root_mask,
    input  wire logic [23:0] nat_mask,
    output logic [23:0]      rgb
);

    logic [15:0] pr_reg, pg_reg, pb_reg;
    logic [7:0]  off_reg;
    logic        use_const_reg;
    logic [23:0] const_reg;

    logic [7:0]  mul_a;
    logic [7:0]  ch_r, ch_g, ch_b;
    logic [7:0]  off_next;
    logic        use_const_next;
    logic [23:0] const_next;
    logic [31:0] rm32, nm32;

    always_comb
    begin
        rm32           = {8'd0, root_mask};
        nm32           = {8'd0, nat_mask};
        mul_a          = 8'd0;
        ch_r           = pix.rgb[23:16];
        ch_g           = pix.rgb[15:8];
        ch_b           = pix.rgb[7:0];
        off_next       = 8'd0;
        use_const_next = 1'b0;
        const_next     = 24'd0;
        if (pix.chain)
        begin
            mul_a = glow_lvl;
        end
        else if (standby)
        begin
            mul_a = lv.ceil;
        end
        else if (pix.press != 8'd0)
        begin
            // white from baseline up to ceiling
            mul_a    = lv.ceil - lv.base;
            ch_r     = pix.press;
            ch_g     = pix.press;
            ch_b     = pix.press;
            off_next = lv.base;
        end
        else
        begin
            use_const_next = 1'b1;
            if (rm32[pix.slot])
                const_next = {lv.root, 8'd0, lv.root};
            else if (nm32[pix.slot])
                const_next = {lv.base, lv.base, lv.base};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pr_reg        <= {8'd0, mul_a} * {8'd0, ch_r};
            pg_reg        <= {8'd0, mul_a} * {8'd0, ch_g};
            pb_reg        <= {8'd0, mul_a} * {8'd0, ch_b};
            off_reg       <= off_next;
            use_const_reg <= use_const_next;
            const_reg     <= const_next;
        end
    end

    assign rgb = use_const_reg ? const_reg
               : {div255(pr_reg) + off_reg, div255(pg_reg) + off_reg,
                  div255(pb_reg) + off_reg};

endmodule

`default_nettype wire

[sv/plc_store.sv]
// Pad and underglow state memories with registered reads and per-entry valid bits.
`default_nettype none

module plc_store
    import plc_pkg::*;
#(
    parameter int PAD_COUNT  = 24,
    parameter int GLOW_COUNT = 4,
    parameter int PAD_AW     = 5,
    parameter int GLOW_AW    = 2
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [PAD_AW-1:0]  pad_raddr,
    input  wire logic               pad_we,
    input  wire logic [PAD_AW-1:0]  pad_waddr,
    input  wire logic [31:0]        pad_wdata,
    output logic [31:0]             pad_rdata,
    input  wire logic [GLOW_AW-1:0] glow_raddr,
    input  wire logic               glow_we,
    input  wire logic [GLOW_AW-1:0] glow_waddr,
    input  wire logic [23:0]        glow_wdata,
    input  wire logic               glow_clear,
    output logic [23:0]             glow_rdata
);

    // pad entry: press level in [31:24], standby color in [23:0]
    logic [31:0]           pad_mem [PAD_COUNT];
    logic [23:0]           glow_mem [GLOW_COUNT];
    logic [PAD_COUNT-1:0]  pad_valid_reg;
    logic [GLOW_COUNT-1:0] glow_valid_reg;
    logic [31:0]           pad_q_reg;
    logic [23:0]           glow_q_reg;
    logic                  pad_qv_reg;
    logic                  glow_qv_reg;

    always_ff @(posedge clk)
    begin
        if (pad_we)
            pad_mem[pad_waddr] <= pad_wdata;
        pad_q_reg <= pad_mem[pad_raddr];
        if (glow_we)
            glow_mem[glow_waddr] <= glow_wdata;
        glow_q_reg <= glow_mem[glow_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_valid_reg  <= '0;
            glow_valid_reg <= '0;
            pad_qv_reg     <= 1'b0;
            glow_qv_reg    <= 1'b0;
        end
        else
        begin
            if (pad_we)
                pad_valid_reg[pad_waddr] <= 1'b1;
            if (glow_clear)
                glow_valid_reg <= '0;
            else if (glow_we)
                glow_valid_reg[glow_waddr] <= 1'b1;
            pad_qv_reg  <= pad_valid_reg[pad_raddr];
            glow_qv_reg <= glow_valid_reg[glow_raddr];
        end
    end

    assign pad_rdata  = pad_qv_reg ? pad_q_reg : 32'd0;
    assign glow_rdata = glow_qv_reg ? glow_q_reg : GLOW_RGB_RST;

endmodule

`default_nettype wire

[sv/pad_led_color_controller_top.sv]
// Top level of the pad LED color controller: request sequencer, registers and output stage.
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one request: press, standby pad
//   color, standby underglow color, standby mode, service tick or refresh all.
//   px channel (px_valid/px_ready/px) returns the pixel writes a request causes,
//   zero to GLOW_COUNT + PAD_COUNT of them; last_write marks the final one.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the six
//   registers; cfg_ready is always high. Write only while the block is idle.
// Timing:
//   One request is handled at a time. After the lookup, a single-pixel
//   request goes straight to multiply; each pixel of a sweep goes through
//   memory read, load and multiply. Each pixel is then divided into the
//   output register and waits there while px_ready stays low. The pixel
//   rate is set by the sequencer, which runs one pixel at a time through
//   the single shared color unit.
// Reset:
//   Press levels and standby colors read as zero, underglow colors as white,
//   no pixel is written until the first refresh all. cmd_ready stays low
//   after reset and after each register write while the brightness levels
//   settle.
// Stall:
//   A pending pixel write holds in the output register; the sequencer waits.
`default_nettype none

module pad_led_color_controller_top
    import plc_pkg::*;
#(
    parameter int PAD_COUNT  = 24,
    parameter int GLOW_COUNT = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  plc_cmd_t         cmd,
    output logic             px_valid,
    input  wire logic        px_ready,
    output plc_px_t          px,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam int PAD_AW  = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
    localparam int GLOW_AW = (GLOW_COUNT > 1) ? $clog2(GLOW_COUNT) : 1;
    localparam int MAX_CNT = (PAD_COUNT > GLOW_COUNT) ? PAD_COUNT : GLOW_COUNT;
    localparam int CNT_W   = (MAX_CNT > 1) ? $clog2(MAX_CNT) : 1;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_LOOK = 7'b0000010,
        ST_RD   = 7'b0000100,
        ST_LD   = 7'b0001000,
        ST_MUL  = 7'b0010000,
        ST_EMIT = 7'b0100000,
        ST_WAIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [6:0]  ceil_pct_reg, idle_pct_reg, root_pct_reg;
    logic [7:0]  glow_lvl_reg;
    logic [23:0] root_mask_reg, nat_mask_reg;
    logic [2:0]  settle_reg;

    // request and sequencing state
    plc_cmd_t           cmd_reg, cmd_next;
    logic [PAD_AW-1:0]  pad_addr_reg, pad_addr_next;
    logic [GLOW_AW-1:0] glow_addr_reg, glow_addr_next;
    logic               pad_ok_reg, pad_ok_next;
    logic               glow_ok_reg, glow_ok_next;
    logic               ready_flag_reg, ready_flag_next;
    logic               standby_reg, standby_next;
    logic [PAD_AW-1:0]  cursor_reg, cursor_next;
    logic [CNT_W-1:0]   sw_cnt_reg, sw_cnt_next;
    logic               sw_glow_reg, sw_glow_next;
    logic               sw_pads_reg, sw_pads_next;
    plc_pix_t           pix_reg, pix_next;
    plc_px_t            px_reg, px_next;
    logic               px_valid_reg, px_valid_next;

    // memory and color unit hookup
    logic [PAD_AW-1:0]  pad_raddr;
    logic               pad_we;
    logic [31:0]        pad_wdata;
    logic [31:0]        pad_rdata;
    logic [GLOW_AW-1:0] glow_raddr;
    logic               glow_we;
    logic [23:0]        glow_wdata;
    logic               glow_clear;
    logic [23:0]        glow_rdata;
    logic               color_load;
    logic [23:0]        color_rgb;
    plc_levels_t        lv;

    logic               cmd_pad_ok;
    logic               cmd_glow_ok;
    logic [PAD_AW-1:0]  cmd_pad_addr;
    logic [GLOW_AW-1:0] cmd_glow_addr;
    logic [7:0]         pad_m1;
    logic [23:0]        cmd_rgb;
    logic               sw_last;

    assign cfg_ready = 1'b1;
    assign cmd_ready = (state_reg == ST_IDLE) && (settle_reg == 3'd0);
    assign px_valid  = px_valid_reg;
    assign px        = px_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceil_pct_reg  <= CEIL_PCT_RST;
            idle_pct_reg  <= IDLE_PCT_RST;
            root_pct_reg  <= ROOT_PCT_RST;
            glow_lvl_reg  <= GLOW_LVL_RST;
            root_mask_reg <= 24'd0;
            nat_mask_reg  <= 24'd0;
            settle_reg    <= LEVEL_SETTLE;
        end
        else if (cfg_valid)
        begin
            settle_reg <= LEVEL_SETTLE;
            unique case (cfg_index)
                CFG_CEIL_PCT:  ceil_pct_reg  <= cfg_data[6:0];
                CFG_IDLE_PCT:  idle_pct_reg  <= cfg_data[6:0];
                CFG_ROOT_PCT:  root_pct_reg  <= cfg_data[6:0];
                CFG_GLOW_LVL:  glow_lvl_reg  <= cfg_data[7:0];
                CFG_ROOT_MASK: root_mask_reg <= cfg_data;
                CFG_NAT_MASK:  nat_mask_reg  <= cfg_data;
                default: ;
            endcase
        end
        else if (settle_reg != 3'd0)
        begin
            settle_reg <= settle_reg - 3'd1;
        end
    end

    // ---------------- request decode at accept ----------------
    always_comb
    begin
        pad_m1        = cmd.logical_pad - 8'd1;
        cmd_pad_ok    = (cmd.logical_pad >= 8'd1) && (cmd.logical_pad <= 8'(PAD_COUNT));
        cmd_glow_ok   = cmd.underglow_index < 8'(GLOW_COUNT);
        cmd_pad_addr  = cmd_pad_ok ? pad_m1[PAD_AW-1:0] : '0;
        cmd_glow_addr = cmd_glow_ok ? cmd.underglow_index[GLOW_AW-1:0] : '0;
        cmd_rgb       = {cmd_reg.red_in, cmd_reg.green_in, cmd_reg.blue_in};
    end

    assign sw_last = sw_glow_reg ? (!sw_pads_reg && (sw_cnt_reg == CNT_W'(GLOW_COUNT - 1)))
                                 : (sw_cnt_reg == CNT_W'(PAD_COUNT - 1));

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        pad_addr_next   = pad_addr_reg;
        glow_addr_next  = glow_addr_reg;
        pad_ok_next     = pad_ok_reg;
        glow_ok_next    = glow_ok_reg;
        ready_flag_next = ready_flag_reg;
        standby_next    = standby_reg;
        cursor_next     = cursor_reg;
        sw_cnt_next     = sw_cnt_reg;
        sw_glow_next    = sw_glow_reg;
        sw_pads_next    = sw_pads_reg;
        pix_next        = pix_reg;
        px_next         = px_reg;
        px_valid_next   = px_valid_reg;

        pad_raddr  = sw_cnt_reg[PAD_AW-1:0];
        glow_raddr = sw_cnt_reg[GLOW_AW-1:0];
        pad_we     = 1'b0;
        pad_wdata  = pad_rdata;
        glow_we    = 1'b0;
        glow_wdata = cmd_rgb;
        glow_clear = 1'b0;
        color_load = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // reads issued straight from the incoming request
                pad_raddr  = (cmd.req_type == REQ_TICK) ? cursor_reg : cmd_pad_addr;
                glow_raddr = cmd_glow_addr;
                if (cmd_valid && cmd_ready)
                begin
                    cmd_next       = cmd;
                    pad_addr_next  = cmd_pad_addr;
                    glow_addr_next = cmd_glow_addr;
                    pad_ok_next    = cmd_pad_ok;
                    glow_ok_next   = cmd_glow_ok;
                    state_next     = ST_LOOK;
                end
            end

            ST_LOOK:
            begin
                state_next   = ST_IDLE;
                sw_cnt_next  = '0;
                sw_glow_next = 1'b1;
                sw_pads_next = 1'b0;
                case (cmd_reg.req_type)
                    REQ_PRESS:
                    begin
                        if (!standby_reg && pad_ok_reg
                            && (pad_rdata[31:24] != cmd_reg.press_level))
                        begin
                            pad_we    = 1'b1;
                            pad_wdata = {cmd_reg.press_level, pad_rdata[23:0]};
                            pix_next  = '{chain: 1'b0, slot: 5'(pad_addr_reg),
                                          press: cmd_reg.press_level,
                                          rgb: pad_rdata[23:0], last: 1'b1};
                            if (ready_flag_reg)
                                state_next = ST_MUL;
                        end
                    end
                    REQ_PAD_RGB:
                    begin
                        if (standby_reg && pad_ok_reg && (pad_rdata[23:0] != cmd_rgb))
                        begin
                            pad_we    = 1'b1;
                            pad_wdata = {pad_rdata[31:24], cmd_rgb};
                            pix_next  = '{chain: 1'b0, slot: 5'(pad_addr_reg),
                                          press: pad_rdata[31:24],
                                          rgb: cmd_rgb, last: 1'b1};
                            if (ready_flag_reg)
                                state_next = ST_MUL;
                        end
                    end
                    REQ_GLOW_RGB:
                    begin
                        if (standby_reg && glow_ok_reg && (glow_rdata != cmd_rgb))
                        begin
                            glow_we = 1'b1;
                            if (ready_flag_reg)
                                state_next = ST_RD;
                        end
                    end
                    REQ_STANDBY:
                    begin
                        standby_next = cmd_reg.standby_on;
                        if (!cmd_reg.standby_on)
                        begin
                            // leaving standby restores white underglow
                            glow_clear = 1'b1;
                            if (ready_flag_reg)
                                state_next = ST_RD;
                        end
                    end
                    REQ_TICK:
                    begin
                        if (ready_flag_reg)
                        begin
                            pix_next = '{chain: 1'b0, slot: 5'(cursor_reg),
                                         press: pad_rdata[31:24],
                                         rgb: pad_rdata[23:0], last: 1'b1};
                            cursor_next = (cursor_reg == PAD_AW'(PAD_COUNT - 1))
                                        ? '0 : cursor_reg + PAD_AW'(1);
                            state_next = ST_MUL;
                        end
                    end
                    REQ_REFRESH:
                    begin
                        ready_flag_next = 1'b1;
                        sw_pads_next    = 1'b1;
                        state_next      = ST_RD;
                    end
                    default: ;
                endcase
            end

            ST_RD:
            begin
                state_next = ST_LD;
            end

            ST_LD:
            begin
                if (sw_glow_reg)
                    pix_next = '{chain: 1'b1, slot: 5'(sw_cnt_reg), press: 8'd0,
                                 rgb: glow_rdata, last: sw_last};
                else
                    pix_next = '{chain: 1'b0, slot: 5'(sw_cnt_reg),
                                 press: pad_rdata[31:24], rgb: pad_rdata[23:0],
                                 last: sw_last};
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                color_load = 1'b1;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                px_next = '{chain_sel: pix_reg.chain, pixel_slot: pix_reg.slot,
                            red_out: color_rgb[23:16], green_out: color_rgb[15:8],
                            blue_out: color_rgb[7:0], last_write: pix_reg.last};
                px_valid_next = 1'b1;
                state_next    = ST_WAIT;
            end

            ST_WAIT:
            begin
                if (px_ready)
                begin
                    px_valid_next = 1'b0;
                    if (pix_reg.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RD;
                        if (sw_glow_reg && (sw_cnt_reg == CNT_W'(GLOW_COUNT - 1)))
                        begin
                            sw_glow_next = 1'b0;
                            sw_cnt_next  = '0;
                        end
                        else
                        begin
                            sw_cnt_next = sw_cnt_reg + CNT_W'(1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ready_flag_reg <= 1'b0;
            standby_reg    <= 1'b0;
            cursor_reg     <= '0;
            sw_cnt_reg     <= '0;
            sw_glow_reg    <= 1'b0;
            sw_pads_reg    <= 1'b0;
            px_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ready_flag_reg <= ready_flag_next;
            standby_reg    <= standby_next;
            cursor_reg     <= cursor_next;
            sw_cnt_reg     <= sw_cnt_next;
            sw_glow_reg    <= sw_glow_next;
            sw_pads_reg    <= sw_pads_next;
            px_valid_reg   <= px_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pad_addr_reg  <= pad_addr_next;
        glow_addr_reg <= glow_addr_next;
        pad_ok_reg    <= pad_ok_next;
        glow_ok_reg   <= glow_ok_next;
        pix_reg       <= pix_next;
        px_reg        <= px_next;
    end

    // ---------------- datapath units ----------------
    plc_store #(
        .PAD_COUNT  (PAD_COUNT),
        .GLOW_COUNT (GLOW_COUNT),
        .PAD_AW     (PAD_AW),
        .GLOW_AW    (GLOW_AW)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .pad_raddr  (pad_raddr),
        .pad_we     (pad_we),
        .pad_waddr  (pad_addr_reg),
        .pad_wdata  (pad_wdata),
        .pad_rdata  (pad_rdata),
        .glow_raddr (glow_raddr),
        .glow_we    (glow_we),
        .glow_waddr (glow_addr_reg),
        .glow_wdata (glow_wdata),
        .glow_clear (glow_clear),
        .glow_rdata (glow_rdata)
    );

    plc_levels u_levels (
        .clk      (clk),
        .ceil_pct (ceil_pct_reg),
        .idle_pct (idle_pct_reg),
        .root_pct (root_pct_reg),
        .lv       (lv)
    );

    plc_color u_color (
        .clk       (clk),
        .load      (color_load),
        .pix       (pix_reg),
        .standby   (standby_reg),
        .lv        (lv),
        .glow_lvl  (glow_lvl_reg),
        .root_mask (root_mask_reg),
        .nat_mask  (nat_mask_reg),
        .rgb       (color_rgb)
    );

endmodule

`default_nettype wire

[tb/plc_pixel_checker.sv]
// Pixel write checker for the pad LED color controller: predicts writes and compares them.
module plc_pixel_checker
    import plc_pkg::*;
#(
    parameter int PAD_COUNT  = 24,
    parameter int GLOW_COUNT = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    input  wire logic        cmd_ready,
    input  plc_cmd_t         cmd,
    input  wire logic        px_valid,
    input  wire logic        px_ready,
    input  plc_px_t          px,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    output int               pixel_errors,
    output int               px_pending,
    output int               live_requests
);

    logic [6:0]  ceil_pct;
    logic [6:0]  idle_pct;
    logic [6:0]  root_pct;
    logic [7:0]  glow_lvl;
    logic [23:0] root_mask;
    logic [23:0] nat_mask;

    logic [7:0]  press_lvl   [PAD_COUNT];
    logic [23:0] standby_rgb [PAD_COUNT];
    logic [23:0] glow_rgb    [GLOW_COUNT];
    int unsigned cursor;
    bit          lit;
    bit          in_standby;

    plc_px_t     expected_px[$];

    function automatic int unsigned pct_of(input logic [6:0] p);
        return (p > PCT_MAX) ? PCT_MAX : p;
    endfunction

    // full * c / 255, truncated
    function automatic logic [7:0] frac255(input int unsigned full, input logic [7:0] c);
        int unsigned t;
        t = full * c / 255;
        return t[7:0];
    endfunction

    function automatic logic [23:0] pad_color(input int unsigned idx);
        int unsigned ceil_l;
        int unsigned base_l;
        int unsigned root_l;
        int unsigned lv;
        ceil_l = 255 * pct_of(ceil_pct) / 100;
        base_l = ceil_l * pct_of(idle_pct) / 100;
        root_l = ceil_l * pct_of(root_pct) / 100;
        if (in_standby)
            return {frac255(ceil_l, standby_rgb[idx][23:16]),
                    frac255(ceil_l, standby_rgb[idx][15:8]),
                    frac255(ceil_l, standby_rgb[idx][7:0])};
        if (press_lvl[idx] != 8'd0) begin
            lv = base_l + (ceil_l - base_l) * press_lvl[idx] / 255;
            return {3{lv[7:0]}};
        end
        // root wins over natural
        if (idx < 24 && root_mask[idx])
            return {root_l[7:0], 8'd0, root_l[7:0]};
        if (idx < 24 && nat_mask[idx])
            return {3{base_l[7:0]}};
        return 24'd0;
    endfunction

    task automatic push_px(input logic chain, input int unsigned slot,
                           input logic [23:0] rgb, input logic last);
        plc_px_t e;
        e.chain_sel  = chain;
        e.pixel_slot = slot[4:0];
        e.red_out    = rgb[23:16];
        e.green_out  = rgb[15:8];
        e.blue_out   = rgb[7:0];
        e.last_write = last;
        expected_px.push_back(e);
    endtask

    task automatic push_glow(input logic last);
        for (int i = 0; i < GLOW_COUNT; i++)
            push_px(1'b1, i, {frac255(glow_lvl, glow_rgb[i][23:16]),
                              frac255(glow_lvl, glow_rgb[i][15:8]),
                              frac255(glow_lvl, glow_rgb[i][7:0])},
                    last && (i == GLOW_COUNT - 1));
    endtask

    task automatic predict_request(input plc_cmd_t c);
        logic [23:0] rgb;
        int unsigned idx;
        bit          pad_ok;
        rgb    = {c.red_in, c.green_in, c.blue_in};
        pad_ok = c.logical_pad >= 1 && c.logical_pad <= PAD_COUNT;
        idx    = pad_ok ? c.logical_pad - 1 : 0;
        case (c.req_type)
            REQ_PRESS:
                if (!in_standby && pad_ok && press_lvl[idx] != c.press_level) begin
                    press_lvl[idx] = c.press_level;
                    live_requests++;
                    if (lit)
                        push_px(1'b0, idx, pad_color(idx), 1'b1);
                end
            REQ_PAD_RGB:
                if (in_standby && pad_ok && standby_rgb[idx] != rgb) begin
                    standby_rgb[idx] = rgb;
                    live_requests++;
                    if (lit)
                        push_px(1'b0, idx, pad_color(idx), 1'b1);
                end
            REQ_GLOW_RGB:
                if (in_standby && c.underglow_index < GLOW_COUNT
                    && glow_rgb[c.underglow_index] != rgb) begin
                    glow_rgb[c.underglow_index] = rgb;
                    live_requests++;
                    if (lit)
                        push_glow(1'b1);
                end
            REQ_STANDBY:
            begin
                in_standby = c.standby_on;
                live_requests++;
                if (!c.standby_on) begin
                    for (int i = 0; i < GLOW_COUNT; i++)
                        glow_rgb[i] = GLOW_RGB_RST;
                    if (lit)
                        push_glow(1'b1);
                end
            end
            REQ_TICK:
                if (lit) begin
                    if (cursor >= PAD_COUNT)
                        cursor = 0;
                    push_px(1'b0, cursor, pad_color(cursor), 1'b1);
                    cursor = (cursor + 1) % PAD_COUNT;
                    live_requests++;
                end
            REQ_REFRESH:
            begin
                lit = 1'b1;
                live_requests++;
                push_glow(1'b0);
                for (int i = 0; i < PAD_COUNT; i++)
                    push_px(1'b0, i, pad_color(i), i == PAD_COUNT - 1);
            end
            default:
                ;
        endcase
    endtask

    task automatic flag_error(input string msg);
        pixel_errors++;
        if (pixel_errors <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        plc_px_t e;
        if (!rst_n) begin
            ceil_pct  = CEIL_PCT_RST;
            idle_pct  = IDLE_PCT_RST;
            root_pct  = ROOT_PCT_RST;
            glow_lvl  = GLOW_LVL_RST;
            root_mask = '0;
            nat_mask  = '0;
            for (int i = 0; i < PAD_COUNT; i++) begin
                press_lvl[i]   = '0;
                standby_rgb[i] = '0;
            end
            for (int i = 0; i < GLOW_COUNT; i++)
                glow_rgb[i] = GLOW_RGB_RST;
            cursor        = 0;
            lit           = 1'b0;
            in_standby    = 1'b0;
            expected_px.delete();
            pixel_errors  = 0;
            live_requests = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_CEIL_PCT:  ceil_pct  = cfg_data[6:0];
                    CFG_IDLE_PCT:  idle_pct  = cfg_data[6:0];
                    CFG_ROOT_PCT:  root_pct  = cfg_data[6:0];
                    CFG_GLOW_LVL:  glow_lvl  = cfg_data[7:0];
                    CFG_ROOT_MASK: root_mask = cfg_data;
                    CFG_NAT_MASK:  nat_mask  = cfg_data;
                    default:       ;
                endcase
            if (px_valid && px_ready) begin
                if (expected_px.size() == 0) begin
                    flag_error($sformatf("unexpected pixel write: chain %0d slot %0d rgb %h last %0d",
                        px.chain_sel, px.pixel_slot, {px.red_out, px.green_out, px.blue_out},
                        px.last_write));
                end else begin
                    e = expected_px.pop_front();
                    if (px.chain_sel !== e.chain_sel || px.pixel_slot !== e.pixel_slot
                        || px.red_out !== e.red_out || px.green_out !== e.green_out
                        || px.blue_out !== e.blue_out || px.last_write !== e.last_write)
                        flag_error($sformatf(
                            "pixel mismatch: exp chain %0d slot %0d rgb %h last %0d, got %0d %0d %h %0d",
                            e.chain_sel, e.pixel_slot, {e.red_out, e.green_out, e.blue_out},
                            e.last_write, px.chain_sel, px.pixel_slot,
                            {px.red_out, px.green_out, px.blue_out}, px.last_write));
                end
            end
            if (cmd_valid && cmd_ready)
                predict_request(cmd);
        end
        px_pending = expected_px.size();
    end

endmodule

[tb/tb.sv]
// Testbench top for the pad LED color controller: clock, reset, request stimulus and verdict.
module tb;
    import plc_pkg::*;

    localparam int PADS  = 24;
    localparam int GLOWS = 4;

    // request codes the block does not use; they must do nothing
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;
    // register indexes beyond the six registers
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    // A refresh all is 28 writes; the worst quiet stretch is the forced output
    // hold-off below plus a random stall, so this leaves a wide margin.
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 300;
    // a request that writes nothing may still be in flight when the queue empties
    localparam int SETTLE_CYCLES = 12;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    plc_cmd_t  cmd       = '0;
    logic      px_ready  = 1'b0;
    logic      cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;

    logic      cmd_ready;
    logic      px_valid;
    plc_px_t   px;
    logic      cfg_ready;

    int pixel_errors;
    int px_pending;
    int live_requests;

    // idle percentages for the current phase
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // long output hold-off: the stimulus bumps hold_seq, the receiver counts it out
    int hold_seq  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int quiet_cycles = 0;

    always #2 clk = ~clk;

    pad_led_color_controller_top #(
        .PAD_COUNT  (PADS),
        .GLOW_COUNT (GLOWS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .px_valid  (px_valid),
        .px_ready  (px_ready),
        .px        (px),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    plc_pixel_checker #(
        .PAD_COUNT  (PADS),
        .GLOW_COUNT (GLOWS)
    ) pixel_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .px_valid      (px_valid),
        .px_ready      (px_ready),
        .px            (px),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_errors  (pixel_errors),
        .px_pending    (px_pending),
        .live_requests (live_requests)
    );

    // Pixel receiver: a forced hold-off takes priority, otherwise random stalls
    // at the phase's rate (zero means always ready).
    always @(posedge clk)
    begin
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            px_ready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            px_ready <= 1'b0;
        end else begin
            px_ready <= 1'b1;
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (px_valid && px_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic plc_cmd_t make_req(input logic [2:0] kind, input logic [7:0] pad,
                                          input logic [7:0] gidx, input logic [7:0] lvl,
                                          input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic on);
        plc_cmd_t c;
        c.req_type        = kind;
        c.logical_pad     = pad;
        c.underglow_index = gidx;
        c.press_level     = lvl;
        c.red_in          = r;
        c.green_in        = g;
        c.blue_in         = b;
        c.standby_on      = on;
        return c;
    endfunction

    // Mostly valid pads and pixels with random content; a few bad indexes and
    // unused codes as noise. Refresh is kept rare since it is 28 writes.
    function automatic plc_cmd_t rand_req();
        plc_cmd_t    c;
        int unsigned pick;
        int unsigned lvl_pick;
        c.red_in      = $urandom;
        c.green_in    = $urandom;
        c.blue_in     = $urandom;
        c.standby_on  = $urandom;
        c.logical_pad = ($urandom_range(9) != 0) ? $urandom_range(1, PADS) : $urandom;
        c.underglow_index = ($urandom_range(9) != 0) ? $urandom_range(0, GLOWS - 1) : $urandom;
        lvl_pick = $urandom_range(99);
        if (lvl_pick < 15)
            c.press_level = 8'd0;
        else if (lvl_pick < 30)
            c.press_level = 8'd255;
        else
            c.press_level = $urandom;
        pick = $urandom_range(99);
        if (pick < 32)
            c.req_type = REQ_PRESS;
        else if (pick < 52)
            c.req_type = REQ_TICK;
        else if (pick < 66)
            c.req_type = REQ_PAD_RGB;
        else if (pick < 78)
            c.req_type = REQ_GLOW_RGB;
        else if (pick < 90)
            c.req_type = REQ_STANDBY;
        else if (pick < 95)
            c.req_type = REQ_REFRESH;
        else
            c.req_type = $urandom_range(1) ? REQ_SPARE_A : REQ_SPARE_B;
        return c;
    endfunction

    // Offer one request and wait for accept. Valid is left high so that a
    // following request goes out back to back; it drops only ahead of a gap.
    task automatic send_req(input plc_cmd_t c);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every predicted write has come out.
    task automatic drain();
        cmd_valid <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (px_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Percent fields carry junk above bit 6 to show the upper bits are dropped.
    task automatic set_regs(input logic [6:0] ceil_p, input logic [6:0] idle_p,
                            input logic [6:0] root_p, input logic [7:0] glow_l,
                            input logic [23:0] root_m, input logic [23:0] nat_m);
        logic [23:0] d;
        d = $urandom; d[6:0] = ceil_p; write_reg(CFG_CEIL_PCT, d);
        d = $urandom; d[6:0] = idle_p; write_reg(CFG_IDLE_PCT, d);
        d = $urandom; d[6:0] = root_p; write_reg(CFG_ROOT_PCT, d);
        d = $urandom; d[7:0] = glow_l; write_reg(CFG_GLOW_LVL, d);
        write_reg(CFG_ROOT_MASK, root_m);
        write_reg(CFG_NAT_MASK, nat_m);
        cfg_valid <= 1'b0;
    endtask

    // Random requests until enough of them have had an effect.
    task automatic run_phase(input int count, input int send_pct, input int stall);
        int goal;
        send_idle_pct = send_pct;
        stall_pct    <= stall;
        goal = live_requests + count;
        while (live_requests < goal)
            send_req(rand_req());
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Before the first refresh all: nothing may be written, but the press
        // is still stored. Unused codes do nothing.
        send_req(make_req(REQ_TICK,    8'd1, 8'd0, 8'd0,   8'h00, 8'h00, 8'h00, 1'b0));
        send_req(make_req(REQ_PRESS,   8'd3, 8'd0, 8'd200, 8'h00, 8'h00, 8'h00, 1'b0));
        send_req(make_req(REQ_SPARE_A, 8'd2, 8'd1, 8'd9,   8'hFF, 8'hFF, 8'hFF, 1'b1));
        send_req(make_req(REQ_SPARE_B, 8'd4, 8'd2, 8'd7,   8'hAA, 8'h55, 8'hAA, 1'b1));
        // first refresh all runs on the reset register values
        send_req(make_req(REQ_REFRESH, 8'd0, 8'd0, 8'd0,   8'h00, 8'h00, 8'h00, 1'b0));
        drain();

        // Writes to the spare indexes must be harmless. Masks: pad 0 is root and
        // natural (root wins), pad 1 natural, pad 2 root, pad 3 sharp, pad 23 root.
        write_reg(CFG_SPARE_A, 24'hFFFFFF);
        write_reg(CFG_SPARE_B, 24'h000000);
        set_regs(CEIL_PCT_RST, IDLE_PCT_RST, ROOT_PCT_RST, GLOW_LVL_RST,
                 24'h800005, 24'h000F03);
        @(posedge clk);

        // press: bad pads, full level, a repeat that changes nothing, lowest
        // level, back to zero for the idle colors
        send_req(make_req(REQ_PRESS, 8'd0,   8'd0, 8'd50,  8'h00, 8'h00, 8'h00, 1'b0));
        send_req(make_req(REQ_PRESS, 8'd25,  8'd0, 8'd50,  8'h00, 8'h00, 8'h00, 1'b0));
        send_req(make_req(REQ_PRESS, 8'd255, 8'd0, 8'd50,  8'h00, 8'h00, 8'h00, 1'b0));
        send_req(make_req(REQ_PRESS, 8'd1,   8'd0, 8'd255, 8'h00, 8'h00, 8'h00, 1'b0));
        send_req(make_req(REQ_PRESS, 8'd1,   8'd0, 8'd255, 8'h00, 8'h00, 8'h00, 1'b0));
        send_req(make_req(REQ_PRESS, 8'd24,  8'd0, 8'd1,   8'h00, 8'h00, 8'h00, 1'b0));
        send_req(make_req(REQ_PRESS, 8'd1,   8'd0, 8'd0,   8'h00, 8'h00, 8'h00, 1'b0));
        send_req(make_req(REQ_TICK,  8'd0,   8'd0, 8'd0,   8'h00, 8'h00, 8'h00, 1'b0));
        send_req(make_req(REQ_TICK,  8'd0,   8'd0, 8'd0,   8'h00, 8'h00, 8'h00, 1'b0));
        // standby colors are ignored outside standby
        send_req(make_req(REQ_PAD_RGB,  8'd2, 8'd0, 8'd0, 8'hFF, 8'h00, 8'h00, 1'b0));
        send_req(make_req(REQ_GLOW_RGB, 8'd0, 8'd1, 8'd0, 8'h00, 8'hFF, 8'h00, 1'b0));
        send_req(make_req(REQ_STANDBY,  8'd0, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 1'b1));
        // in standby: press ignored, colors stored, unchanged color and bad
        // indexes write nothing
        send_req(make_req(REQ_PRESS,    8'd5,  8'd0,   8'd99, 8'h00, 8'h00, 8'h00, 1'b1));
        send_req(make_req(REQ_PAD_RGB,  8'd1,  8'd0,   8'd0,  8'hFF, 8'hFF, 8'hFF, 1'b1));
        send_req(make_req(REQ_PAD_RGB,  8'd24, 8'd0,   8'd0,  8'h00, 8'h00, 8'h00, 1'b1));
        send_req(make_req(REQ_PAD_RGB,  8'd0,  8'd0,   8'd0,  8'h12, 8'h34, 8'h56, 1'b1));
        send_req(make_req(REQ_GLOW_RGB, 8'd0,  8'd0,   8'd0,  8'h00, 8'h00, 8'h00, 1'b1));
        send_req(make_req(REQ_GLOW_RGB, 8'd0,  8'd3,   8'd0,  8'hFF, 8'h80, 8'h01, 1'b1));
        send_req(make_req(REQ_GLOW_RGB, 8'd0,  8'd4,   8'd0,  8'h11, 8'h22, 8'h33, 1'b1));
        send_req(make_req(REQ_GLOW_RGB, 8'd0,  8'd255, 8'd0,  8'h11, 8'h22, 8'h33, 1'b1));
        // leaving standby restores white underglow; a second "off" writes again
        send_req(make_req(REQ_STANDBY,  8'd0,  8'd0,   8'd0,  8'h00, 8'h00, 8'h00, 1'b0));
        send_req(make_req(REQ_STANDBY,  8'd0,  8'd0,   8'd0,  8'h00, 8'h00, 8'h00, 1'b0));
        send_req(make_req(REQ_REFRESH,  8'd0,  8'd0,   8'd0,  8'h00, 8'h00, 8'h00, 1'b0));

        // reset levels, random masks, no idling
        drain();
        set_regs(CEIL_PCT_RST, IDLE_PCT_RST, ROOT_PCT_RST, GLOW_LVL_RST, $urandom, $urandom);
        run_phase(70, 0, 0);

        // everything dark, slow sender
        drain();
        set_regs(7'd0, 7'd0, 7'd0, 8'd0, $urandom, $urandom);
        run_phase(60, 76, 0);

        // percents past 100 saturate; slow receiver
        drain();
        set_regs(7'd127, 7'd127, 7'd127, 8'd255, 24'hFFFFFF, 24'h000000);
        run_phase(60, 0, 76);

        // full levels, both sides idle now and then
        drain();
        set_regs(PCT_MAX, PCT_MAX, PCT_MAX, 8'd255, 24'h000000, 24'hFFFFFF);
        run_phase(70, 9, 9);

        // Random levels. The receiver holds off for a long stretch while the
        // sender keeps offering, so the output stalls and cmd_ready drops.
        drain();
        set_regs($urandom_range(127), $urandom_range(127), $urandom_range(127), $urandom,
                 $urandom, $urandom);
        send_idle_pct = 0;
        stall_pct    <= 0;
        hold_seq     <= hold_seq + 1;
        send_req(make_req(REQ_REFRESH, 8'd0, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0));
        repeat (20) send_req(rand_req());
        // sender waits for every write before going on
        drain();
        run_phase(60, 0, 0);

        // odd mix of levels, both sides idle now and then
        drain();
        set_regs(7'd50, 7'd0, PCT_MAX, 8'd1, $urandom, $urandom);
        run_phase(60, 9, 9);

        drain();
        if (pixel_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
